// File: rtl/core/stream_header_insert_realign_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the header insert / realign core
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_HEADER_INSERT_REALIGN_CORE_MACROS_SVH
`define STREAM_HEADER_INSERT_REALIGN_CORE_MACROS_SVH

// same-cycle implication
`define SHIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/shir_pkg.sv
// ----------------------------------------------------------------------------
// shir_pkg
// Types and constants of the header insert / realign core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shir_pkg;

	localparam int BEAT_BYTES_DEF   = 8;
	localparam int HEADER_BYTES_DEF = 2;

	localparam int DATA_W  = 64;
	localparam int KEEP_W  = 8;
	localparam int DEST_W  = 16;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int CARRY_W = 16;
	localparam int CKEEP_W = 2;

	localparam logic [CKEEP_W-1:0] HEADER_KEEP_ALL = 2'b11;

	typedef struct packed {
		logic [DATA_W-1:0] beat_data;
		logic [KEEP_W-1:0] beat_keep;
		logic              beat_last;
		logic [DEST_W-1:0] dest_id;
		logic [IP_W-1:0]   peer_addr;
		logic [PORT_W-1:0] peer_port;
		logic [PORT_W-1:0] host_port;
	} in_beat_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic [KEEP_W-1:0] out_keep;
		logic              out_last;
		logic [IP_W-1:0]   out_peer_addr;
		logic [PORT_W-1:0] out_peer_port;
		logic [PORT_W-1:0] out_host_port;
		logic              run_end;
	} out_beat_t;

	typedef struct packed {
		logic               in_packet;
		logic [CARRY_W-1:0] carry_bytes;
		logic [CKEEP_W-1:0] carry_valid;
	} state_t;

	typedef struct packed {
		out_beat_t first;
		logic      tail_en;
		out_beat_t tail;
		state_t    next;
	} realign_t;

endpackage

// File: rtl/core/shir_stream_if.sv
// ----------------------------------------------------------------------------
// shir_stream_if
// Valid/ready stream channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shir_stream_if #(
	parameter type payload_t = shir_pkg::in_beat_t
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/shir_realign.sv
// ----------------------------------------------------------------------------
// shir_realign
// Header insertion and lane shift for one beat, plus carry state update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shir_realign #(
	parameter int BEAT_BYTES   = shir_pkg::BEAT_BYTES_DEF,
	parameter int HEADER_BYTES = shir_pkg::HEADER_BYTES_DEF
) (
	input  shir_pkg::in_beat_t beat,
	input  shir_pkg::state_t   st,
	output shir_pkg::realign_t res
);
	localparam int DW = 8 * BEAT_BYTES;
	localparam int HW = 8 * HEADER_BYTES;

	logic [DW-1:0]           data;
	logic [BEAT_BYTES-1:0]   keep;
	logic [HW-1:0]           top_data;
	logic [HEADER_BYTES-1:0] top_keep;
	logic [HW-1:0]           lo_data;
	logic [HEADER_BYTES-1:0] lo_keep;
	logic [DW-1:0]           o_data;
	logic [BEAT_BYTES-1:0]   o_keep;
	logic                    tail;

	always_comb begin
		data     = beat.beat_data[DW-1:0];
		keep     = beat.beat_keep[BEAT_BYTES-1:0];
		top_data = st.in_packet ? st.carry_bytes[HW-1:0] : beat.dest_id[HW-1:0];
		top_keep = st.in_packet ? st.carry_valid[HEADER_BYTES-1:0]
		                        : shir_pkg::HEADER_KEEP_ALL[HEADER_BYTES-1:0];
		lo_data  = data[HW-1:0];
		lo_keep  = keep[HEADER_BYTES-1:0];
		o_data   = {top_data, data[DW-1:HW]};
		o_keep   = {top_keep, keep[BEAT_BYTES-1:HEADER_BYTES]};
		tail     = beat.beat_last && keep[HEADER_BYTES-1];

		res.first.out_data      = shir_pkg::DATA_W'(o_data);
		res.first.out_keep      = shir_pkg::KEEP_W'(o_keep);
		res.first.out_last      = beat.beat_last && !tail;
		res.first.out_peer_addr = beat.peer_addr;
		res.first.out_peer_port = beat.peer_port;
		res.first.out_host_port = beat.host_port;
		res.first.run_end       = !tail;

		res.tail_en             = tail;
		res.tail.out_data       = shir_pkg::DATA_W'({lo_data, {(DW-HW){1'b0}}});
		res.tail.out_keep       =
			shir_pkg::KEEP_W'({lo_keep, {(BEAT_BYTES-HEADER_BYTES){1'b0}}});
		res.tail.out_last       = 1'b1;
		res.tail.out_peer_addr  = beat.peer_addr;
		res.tail.out_peer_port  = beat.peer_port;
		res.tail.out_host_port  = beat.host_port;
		res.tail.run_end        = 1'b1;

		if (beat.beat_last) begin
			res.next = '0;
		end else begin
			res.next.in_packet   = 1'b1;
			res.next.carry_bytes = shir_pkg::CARRY_W'(lo_data);
			res.next.carry_valid = shir_pkg::CKEEP_W'(lo_keep);
		end
	end
endmodule

// File: rtl/core/stream_header_insert_realign_core.sv
// ----------------------------------------------------------------------------
// stream_header_insert_realign_core
// Inserts a destination header ahead of each packet and realigns the payload.
// ----------------------------------------------------------------------------
// One beat is taken per cycle when the output register is free and no tail
// beat waits; its result appears from the output register in the next cycle.
// A last beat whose first carried lane is valid makes two results; the extra
// tail beat waits in a one-entry tail register and holds input off until it
// moves into the output register. A result waiting in the output register
// does not block input while the output register drains in the same cycle.
`timescale 1ns / 1ps
`include "stream_header_insert_realign_core_macros.svh"

module stream_header_insert_realign_core #(
	parameter int BEAT_BYTES   = shir_pkg::BEAT_BYTES_DEF,
	parameter int HEADER_BYTES = shir_pkg::HEADER_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	shir_stream_if.sink   beat,
	shir_stream_if.source result
);
	shir_pkg::state_t    st_q;
	shir_pkg::realign_t  ra;
	shir_pkg::out_beat_t out_q;
	shir_pkg::out_beat_t tail_q;
	logic                out_valid_q;
	logic                tail_valid_q;
	logic                out_free;
	logic                accept;

	shir_realign #(
		.BEAT_BYTES   (BEAT_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_realign (
		.beat (beat.data),
		.st   (st_q),
		.res  (ra)
	);

	assign out_free     = !out_valid_q || result.ready;
	assign beat.ready   = out_free && !tail_valid_q;
	assign accept       = beat.valid && beat.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= '0;
			out_valid_q  <= 1'b0;
			tail_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q        <= ra.next;
				out_valid_q <= 1'b1;
				if (ra.tail_en) begin
					tail_valid_q <= 1'b1;
				end
			end else if (tail_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				tail_valid_q <= 1'b0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= ra.first;
			if (ra.tail_en) begin
				tail_q <= ra.tail;
			end
		end else if (tail_valid_q && out_free) begin
			out_q <= tail_q;
		end
	end

	`SHIR_ASSERT_NOW(a_tail_behind_out, tail_valid_q, out_valid_q, "tail without output")
	`SHIR_ASSERT_NOW(a_split_has_tail, out_valid_q && !out_q.run_end, tail_valid_q, "tail lost")
	`SHIR_ASSERT_NEXT(a_tail_load, accept && ra.tail_en, tail_valid_q, "tail not captured")
	`SHIR_ASSERT_NEXT(a_mid_packet, accept && !beat.data.beat_last, st_q.in_packet, "state lost")
endmodule
